// ===== hdl/pppu_pkg.sv =====
package pppu_pkg;

   // Field and register width, Q16.16, Q2.30 and Q8.24 alike.
   localparam int DATA_W = 32;
   // Quaternion and rotation products after the Q.30 floor.
   localparam int QPROD_W = 34;
   // Camera-space coordinates: translation plus three rotated terms.
   localparam int CAM_W = 37;
   // Dividend magnitude: camera coordinate scaled by 2^24.
   localparam int NUM_W = CAM_W + 24;
   // Working width of the divider compare.
   localparam int REM_W = CAM_W + DATA_W;
   // One quotient bit or one root bit per pipeline stage.
   localparam int DIV_STEPS = 32;
   localparam int SQRT_STEPS = 32;

   localparam logic signed [CAM_W-1:0] ONE_Q30 = 37'sd1073741824;
   localparam logic signed [49:0] ONE_Q24 = 50'sd16777216;
   localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7FFFFFFF;
   localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh80000000;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_FOCAL_X = 3'd0;
   localparam logic [2:0] CSR_FOCAL_Y = 3'd1;
   localparam logic [2:0] CSR_CENTER_X = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y = 3'd3;
   localparam logic [2:0] CSR_DIST_K1 = 3'd4;
   localparam logic [2:0] CSR_DIST_K2 = 3'd5;

   typedef struct packed {
      logic valid;
      logic zero;
   } pppu_ctl_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         sat32 = INT32_MAX;
      end else if (v < -64'sd2147483648) begin
         sat32 = INT32_MIN;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/pppu_rotate.sv =====
module pppu_rotate import pppu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [DATA_W-1:0] point_x,
   input  logic signed [DATA_W-1:0] point_y,
   input  logic signed [DATA_W-1:0] point_z,
   input  logic signed [DATA_W-1:0] quat_w,
   input  logic signed [DATA_W-1:0] quat_x,
   input  logic signed [DATA_W-1:0] quat_y,
   input  logic signed [DATA_W-1:0] quat_z,
   input  logic signed [DATA_W-1:0] trans_x,
   input  logic signed [DATA_W-1:0] trans_y,
   input  logic signed [DATA_W-1:0] trans_z,
   output logic                     out_valid,
   output logic signed [CAM_W-1:0]  cam_x,
   output logic signed [CAM_W-1:0]  cam_y,
   output logic signed [CAM_W-1:0]  cam_z
);

   // Stage 1: the nine quaternion products, order xx yy zz xy xz yz wx wy wz.
   logic                      v1_ff;
   logic signed [QPROD_W-1:0] qp_ff [0:8];
   logic signed [QPROD_W-1:0] qp_in [0:8];
   logic signed [DATA_W-1:0]  p1_ff [0:2];
   logic signed [DATA_W-1:0]  t1_ff [0:2];

   // Stage 2: rotation matrix, row major.
   logic                      v2_ff;
   logic signed [DATA_W-1:0]  m_ff [0:8];
   logic signed [DATA_W-1:0]  m_in [0:8];
   logic signed [DATA_W-1:0]  p2_ff [0:2];
   logic signed [DATA_W-1:0]  t2_ff [0:2];

   // Stage 3: the nine products of matrix entries with point coordinates.
   logic                      v3_ff;
   logic signed [QPROD_W-1:0] mp_ff [0:8];
   logic signed [QPROD_W-1:0] mp_in [0:8];
   logic signed [DATA_W-1:0]  t3_ff [0:2];

   // Stage 4: camera coordinates.
   logic                      v4_ff;
   logic signed [CAM_W-1:0]   c_ff [0:2];
   logic signed [CAM_W-1:0]   c_in [0:2];

   function automatic logic signed [QPROD_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
      logic signed [63:0] prod;
      prod = 64'(a) * 64'(b);
      qmul = QPROD_W'(prod >>> 30);
   endfunction

   function automatic logic signed [DATA_W-1:0] diag(input logic signed [QPROD_W-1:0] a,
                                                     input logic signed [QPROD_W-1:0] b);
      logic signed [CAM_W-1:0] e;
      e = ONE_Q30 - ((CAM_W'(a) + CAM_W'(b)) <<< 1);
      diag = sat32(64'(e));
   endfunction

   function automatic logic signed [DATA_W-1:0] offd(input logic signed [QPROD_W-1:0] a,
                                                     input logic signed [QPROD_W-1:0] b,
                                                     input logic                      sub);
      logic signed [CAM_W-1:0] e;
      if (sub) begin
         e = (CAM_W'(a) - CAM_W'(b)) <<< 1;
      end else begin
         e = (CAM_W'(a) + CAM_W'(b)) <<< 1;
      end
      offd = sat32(64'(e));
   endfunction

   always_comb begin
      qp_in[0] = qmul(quat_x, quat_x);
      qp_in[1] = qmul(quat_y, quat_y);
      qp_in[2] = qmul(quat_z, quat_z);
      qp_in[3] = qmul(quat_x, quat_y);
      qp_in[4] = qmul(quat_x, quat_z);
      qp_in[5] = qmul(quat_y, quat_z);
      qp_in[6] = qmul(quat_w, quat_x);
      qp_in[7] = qmul(quat_w, quat_y);
      qp_in[8] = qmul(quat_w, quat_z);
   end

   always_comb begin
      m_in[0] = diag(qp_ff[1], qp_ff[2]);
      m_in[1] = offd(qp_ff[3], qp_ff[8], 1'b1);
      m_in[2] = offd(qp_ff[4], qp_ff[7], 1'b0);
      m_in[3] = offd(qp_ff[3], qp_ff[8], 1'b0);
      m_in[4] = diag(qp_ff[0], qp_ff[2]);
      m_in[5] = offd(qp_ff[5], qp_ff[6], 1'b1);
      m_in[6] = offd(qp_ff[4], qp_ff[7], 1'b1);
      m_in[7] = offd(qp_ff[5], qp_ff[6], 1'b0);
      m_in[8] = diag(qp_ff[0], qp_ff[1]);
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         mp_in[i] = qmul(m_ff[i], p2_ff[i % 3]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = CAM_W'(t3_ff[i]) + CAM_W'(mp_ff[3*i]) + CAM_W'(mp_ff[3*i+1])
                   + CAM_W'(mp_ff[3*i+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      qp_ff <= qp_in;
      p1_ff[0] <= point_x;
      p1_ff[1] <= point_y;
      p1_ff[2] <= point_z;
      t1_ff[0] <= trans_x;
      t1_ff[1] <= trans_y;
      t1_ff[2] <= trans_z;
      m_ff <= m_in;
      p2_ff <= p1_ff;
      t2_ff <= t1_ff;
      mp_ff <= mp_in;
      t3_ff <= t2_ff;
      c_ff <= c_in;
   end

   assign out_valid = v4_ff;
   assign cam_x = c_ff[0];
   assign cam_y = c_ff[1];
   assign cam_z = c_ff[2];

endmodule

// ===== hdl/pppu_div_lane.sv =====
module pppu_div_lane import pppu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [CAM_W-1:0]  num,
   input  logic signed [CAM_W-1:0]  den,
   output pppu_ctl_type             out_ctl,
   output logic signed [DATA_W-1:0] quo
);

   // Stage 0 holds the operand magnitudes; stage i+1 holds quotient bit 31-i.
   logic             valid_ff [0:DIV_STEPS];
   logic             zero_ff  [0:DIV_STEPS];
   logic             neg_ff   [0:DIV_STEPS];
   logic             ovf_ff   [0:DIV_STEPS];
   logic [NUM_W-1:0] rem_ff   [0:DIV_STEPS];
   logic [CAM_W-1:0] den_ff   [0:DIV_STEPS];
   logic [DATA_W-1:0] quo_ff  [0:DIV_STEPS];

   logic [NUM_W-1:0]  rem_in [0:DIV_STEPS-1];
   logic [DATA_W-1:0] quo_in [0:DIV_STEPS-1];

   logic [CAM_W-1:0] num_mag;
   logic [CAM_W-1:0] den_mag;

   pppu_ctl_type            out_ctl_ff;
   logic signed [DATA_W-1:0] quo_out_ff;
   logic signed [DATA_W-1:0] quo_out_in;

   assign num_mag = num[CAM_W-1] ? CAM_W'(-num) : CAM_W'(num);
   assign den_mag = den[CAM_W-1] ? CAM_W'(-den) : CAM_W'(den);

   always_comb begin
      for (int i = 0; i < DIV_STEPS; i++) begin
         logic [REM_W-1:0] trial;
         logic             fits;
         trial = REM_W'(den_ff[i]) << (DIV_STEPS - 1 - i);
         fits = REM_W'(rem_ff[i]) >= trial;
         rem_in[i] = fits ? (rem_ff[i] - trial[NUM_W-1:0]) : rem_ff[i];
         quo_in[i] = quo_ff[i] | (DATA_W'(fits) << (DIV_STEPS - 1 - i));
      end
   end

   // Sign, saturation and truncation toward zero.
   always_comb begin
      logic signed [DATA_W+1:0] sv;
      sv = $signed({2'b00, quo_ff[DIV_STEPS]});
      if (neg_ff[DIV_STEPS]) begin
         sv = -sv;
      end
      if (ovf_ff[DIV_STEPS]) begin
         quo_out_in = neg_ff[DIV_STEPS] ? INT32_MIN : INT32_MAX;
      end else begin
         quo_out_in = sat32(64'(sv));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_ctl_ff.valid <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 0; i < DIV_STEPS; i++) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         out_ctl_ff.valid <= valid_ff[DIV_STEPS];
      end
      zero_ff[0] <= (den == '0);
      neg_ff[0]  <= num[CAM_W-1] ^ den[CAM_W-1];
      ovf_ff[0]  <= (num_mag >> 8) >= den_mag;
      rem_ff[0]  <= {num_mag, 24'b0};
      den_ff[0]  <= den_mag;
      quo_ff[0]  <= '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         zero_ff[i+1] <= zero_ff[i];
         neg_ff[i+1]  <= neg_ff[i];
         ovf_ff[i+1]  <= ovf_ff[i];
         den_ff[i+1]  <= den_ff[i];
         rem_ff[i+1]  <= rem_in[i];
         quo_ff[i+1]  <= quo_in[i];
      end
      out_ctl_ff.zero <= zero_ff[DIV_STEPS];
      quo_out_ff <= quo_out_in;
   end

   assign out_ctl = out_ctl_ff;
   assign quo = quo_out_ff;

endmodule

// ===== hdl/pppu_isqrt.sv =====
module pppu_isqrt import pppu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  pppu_ctl_type             in_ctl,
   input  logic signed [DATA_W-1:0] in_nx,
   input  logic signed [DATA_W-1:0] in_ny,
   output pppu_ctl_type             out_ctl,
   output logic [DATA_W-1:0]        root,
   output logic [63:0]              sq,
   output logic signed [DATA_W-1:0] out_nx,
   output logic signed [DATA_W-1:0] out_ny
);

   // Squares stage.
   pppu_ctl_type            sqr_ctl_ff;
   logic [62:0]              sqx_ff;
   logic [62:0]              sqy_ff;
   logic signed [DATA_W-1:0] sqr_nx_ff;
   logic signed [DATA_W-1:0] sqr_ny_ff;
   logic signed [63:0]       sqx_wide;
   logic signed [63:0]       sqy_wide;

   // Stage 0 holds the sum; stage i+1 holds root bit 31-i.
   pppu_ctl_type            ctl_ff [0:SQRT_STEPS];
   logic [63:0]              n_ff   [0:SQRT_STEPS];
   logic [63:0]              res_ff [0:SQRT_STEPS];
   logic [63:0]              sq_ff  [0:SQRT_STEPS];
   logic signed [DATA_W-1:0] nx_ff  [0:SQRT_STEPS];
   logic signed [DATA_W-1:0] ny_ff  [0:SQRT_STEPS];
   logic [63:0]              n_in   [0:SQRT_STEPS-1];
   logic [63:0]              res_in [0:SQRT_STEPS-1];

   assign sqx_wide = 64'(in_nx) * 64'(in_nx);
   assign sqy_wide = 64'(in_ny) * 64'(in_ny);

   always_comb begin
      for (int i = 0; i < SQRT_STEPS; i++) begin
         logic [63:0] bitv;
         logic [63:0] trial;
         bitv = 64'd1 << (2 * (SQRT_STEPS - 1 - i));
         trial = res_ff[i] + bitv;
         if (n_ff[i] >= trial) begin
            n_in[i] = n_ff[i] - trial;
            res_in[i] = (res_ff[i] >> 1) + bitv;
         end else begin
            n_in[i] = n_ff[i];
            res_in[i] = res_ff[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqr_ctl_ff.valid <= 1'b0;
         for (int i = 0; i <= SQRT_STEPS; i++) begin
            ctl_ff[i].valid <= 1'b0;
         end
      end else begin
         sqr_ctl_ff.valid <= in_ctl.valid;
         ctl_ff[0].valid <= sqr_ctl_ff.valid;
         for (int i = 0; i < SQRT_STEPS; i++) begin
            ctl_ff[i+1].valid <= ctl_ff[i].valid;
         end
      end
      sqr_ctl_ff.zero <= in_ctl.zero;
      sqx_ff <= sqx_wide[62:0];
      sqy_ff <= sqy_wide[62:0];
      sqr_nx_ff <= in_nx;
      sqr_ny_ff <= in_ny;
      ctl_ff[0].zero <= sqr_ctl_ff.zero;
      n_ff[0]   <= 64'(sqx_ff) + 64'(sqy_ff);
      sq_ff[0]  <= 64'(sqx_ff) + 64'(sqy_ff);
      res_ff[0] <= '0;
      nx_ff[0]  <= sqr_nx_ff;
      ny_ff[0]  <= sqr_ny_ff;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         ctl_ff[i+1].zero <= ctl_ff[i].zero;
         n_ff[i+1]   <= n_in[i];
         res_ff[i+1] <= res_in[i];
         sq_ff[i+1]  <= sq_ff[i];
         nx_ff[i+1]  <= nx_ff[i];
         ny_ff[i+1]  <= ny_ff[i];
      end
   end

   assign out_ctl = ctl_ff[SQRT_STEPS];
   assign root = res_ff[SQRT_STEPS][DATA_W-1:0];
   assign sq = sq_ff[SQRT_STEPS];
   assign out_nx = nx_ff[SQRT_STEPS];
   assign out_ny = ny_ff[SQRT_STEPS];

endmodule

// ===== hdl/pppu_distort.sv =====
module pppu_distort import pppu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  pppu_ctl_type             in_ctl,
   input  logic [DATA_W-1:0]        root,
   input  logic [63:0]              sq,
   input  logic signed [DATA_W-1:0] nx,
   input  logic signed [DATA_W-1:0] ny,
   input  logic signed [DATA_W-1:0] focal_x,
   input  logic signed [DATA_W-1:0] focal_y,
   input  logic signed [DATA_W-1:0] center_x,
   input  logic signed [DATA_W-1:0] center_y,
   input  logic signed [DATA_W-1:0] dist_k1,
   input  logic signed [DATA_W-1:0] dist_k2,
   output pppu_ctl_type             out_ctl,
   output logic signed [DATA_W-1:0] image_u,
   output logic signed [DATA_W-1:0] image_v
);

   pppu_ctl_type ctl_ff [1:6];
   logic signed [DATA_W-1:0] nx_ff [1:2];
   logic signed [DATA_W-1:0] ny_ff [1:2];

   // Stage 1: k1*r and k2*r*r, the latter split at bit 48 of r*r.
   logic signed [64:0] pa_ff;
   logic signed [48:0] pbh_ff;
   logic signed [56:0] pbl_ff;
   // Stage 2: scale factor.
   logic signed [DATA_W-1:0] s_ff;
   logic signed [49:0]       s_wide;
   // Stage 3 and 4: distorted coordinates.
   logic signed [63:0] sx_ff;
   logic signed [63:0] sy_ff;
   logic signed [DATA_W-1:0] dx_ff;
   logic signed [DATA_W-1:0] dy_ff;
   // Stage 5 and 6: focal scaling and principal point.
   logic signed [63:0] fx_ff;
   logic signed [63:0] fy_ff;
   logic signed [DATA_W-1:0] u_ff;
   logic signed [DATA_W-1:0] v_ff;
   logic signed [DATA_W-1:0] u_in;
   logic signed [DATA_W-1:0] v_in;

   assign s_wide = ONE_Q24 + 50'(pa_ff >>> 24) + 50'(pbh_ff) + 50'(pbl_ff >>> 24);

   always_comb begin
      logic signed [40:0] fu;
      logic signed [40:0] fv;
      fu = 41'(fx_ff >>> 24) + 41'(center_x);
      fv = 41'(fy_ff >>> 24) + 41'(center_y);
      if (ctl_ff[5].zero) begin
         u_in = '0;
         v_in = '0;
      end else begin
         u_in = sat32(64'(fu));
         v_in = sat32(64'(fv));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 6; i++) begin
            ctl_ff[i].valid <= 1'b0;
         end
      end else begin
         ctl_ff[1].valid <= in_ctl.valid;
         for (int i = 1; i < 6; i++) begin
            ctl_ff[i+1].valid <= ctl_ff[i].valid;
         end
      end
      ctl_ff[1].zero <= in_ctl.zero;
      for (int i = 1; i < 6; i++) begin
         ctl_ff[i+1].zero <= ctl_ff[i].zero;
      end
      nx_ff[1] <= nx;
      ny_ff[1] <= ny;
      nx_ff[2] <= nx_ff[1];
      ny_ff[2] <= ny_ff[1];
      pa_ff  <= 65'(dist_k1) * $signed({1'b0, root});
      pbh_ff <= 49'(dist_k2) * $signed({1'b0, sq[63:48]});
      pbl_ff <= 57'(dist_k2) * $signed({1'b0, sq[47:24]});
      s_ff   <= sat32(64'(s_wide));
      sx_ff  <= 64'(s_ff) * 64'(nx_ff[2]);
      sy_ff  <= 64'(s_ff) * 64'(ny_ff[2]);
      dx_ff  <= sat32(sx_ff >>> 24);
      dy_ff  <= sat32(sy_ff >>> 24);
      fx_ff  <= 64'(focal_x) * 64'(dx_ff);
      fy_ff  <= 64'(focal_y) * 64'(dy_ff);
      u_ff   <= u_in;
      v_ff   <= v_in;
   end

   assign out_ctl = ctl_ff[6];
   assign image_u = u_ff;
   assign image_v = v_ff;

endmodule

// ===== hdl/pinhole_point_projection_unit.sv =====
// Pinhole point projection unit.
// A request carries a world point, a pose quaternion and a translation. It is
// taken at a rising clock edge where start is high and busy is low; busy is
// always low, so a new request may be issued in every cycle.
// The unit rotates and translates the point into camera space, divides by the
// depth, applies the two-term radial distortion and maps the result through
// the focal lengths and the principal point, all in fixed point.
// The result of a request appears on the rsp_ ports for exactly one cycle, with
// rsp_valid high, after the rotation, division, radius and distortion stages.
// Results come out in request order at up to one per cycle. Most of the
// pipeline depth lies in the two bit-serial pipelines: the depth divider, one
// quotient bit per stage, and the square root of the radius, one root bit per
// stage, 32 stages each.
// The receiver cannot hold results off, so nothing in the pipeline ever stalls.
// A zero depth gives zero coordinates with rsp_zero_depth set.
// The csr_ port writes one of the six calibration registers, chosen by csr_index;
// write them only while no request is in flight. Indexes beyond the six are ignored.
// Reset empties the pipeline, drops any request in flight and restores the
// calibration registers to unit focal lengths and no offset or distortion.
module pinhole_point_projection_unit import pppu_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   input  logic signed [DATA_W-1:0] req_point_z,
   input  logic signed [DATA_W-1:0] req_quat_w,
   input  logic signed [DATA_W-1:0] req_quat_x,
   input  logic signed [DATA_W-1:0] req_quat_y,
   input  logic signed [DATA_W-1:0] req_quat_z,
   input  logic signed [DATA_W-1:0] req_trans_x,
   input  logic signed [DATA_W-1:0] req_trans_y,
   input  logic signed [DATA_W-1:0] req_trans_z,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_image_u,
   output logic signed [DATA_W-1:0] rsp_image_v,
   output logic                     rsp_zero_depth,
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   // Pipeline depth from request to result, used by the checks below.
   localparam int LATENCY = 78;

   logic signed [DATA_W-1:0] focal_x_ff;
   logic signed [DATA_W-1:0] focal_y_ff;
   logic signed [DATA_W-1:0] center_x_ff;
   logic signed [DATA_W-1:0] center_y_ff;
   logic signed [DATA_W-1:0] dist_k1_ff;
   logic signed [DATA_W-1:0] dist_k2_ff;

   logic                    cam_valid;
   logic signed [CAM_W-1:0] cam_x;
   logic signed [CAM_W-1:0] cam_y;
   logic signed [CAM_W-1:0] cam_z;

   pppu_ctl_type            div_ctl_x;
   pppu_ctl_type            div_ctl_y;
   logic signed [DATA_W-1:0] norm_x;
   logic signed [DATA_W-1:0] norm_y;

   pppu_ctl_type            rad_ctl;
   logic [DATA_W-1:0]        rad_root;
   logic [63:0]              rad_sq;
   logic signed [DATA_W-1:0] rad_nx;
   logic signed [DATA_W-1:0] rad_ny;

   pppu_ctl_type            out_ctl;

   // The pipeline never stalls, so a request is taken in every cycle that start is high.
   assign busy = 1'b0;

   // Calibration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 32'sd65536;
         focal_y_ff  <= 32'sd65536;
         center_x_ff <= '0;
         center_y_ff <= '0;
         dist_k1_ff  <= '0;
         dist_k2_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FOCAL_X: begin
               focal_x_ff <= csr_data;
            end
            CSR_FOCAL_Y: begin
               focal_y_ff <= csr_data;
            end
            CSR_CENTER_X: begin
               center_x_ff <= csr_data;
            end
            CSR_CENTER_Y: begin
               center_y_ff <= csr_data;
            end
            CSR_DIST_K1: begin
               dist_k1_ff <= csr_data;
            end
            CSR_DIST_K2: begin
               dist_k2_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Rotation matrix and camera-space point, four stages.
   pppu_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .point_z   (req_point_z),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .trans_x   (req_trans_x),
      .trans_y   (req_trans_y),
      .trans_z   (req_trans_z),
      .out_valid (cam_valid),
      .cam_x     (cam_x),
      .cam_y     (cam_y),
      .cam_z     (cam_z)
   );

   // Perspective division, one lane per image axis, 34 stages each.
   pppu_div_lane u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cam_valid),
      .num      (cam_x),
      .den      (cam_z),
      .out_ctl  (div_ctl_x),
      .quo      (norm_x)
   );

   pppu_div_lane u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cam_valid),
      .num      (cam_y),
      .den      (cam_z),
      .out_ctl  (div_ctl_y),
      .quo      (norm_y)
   );

   // Radius of the normalized point, 34 stages.
   pppu_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (div_ctl_x),
      .in_nx   (norm_x),
      .in_ny   (norm_y),
      .out_ctl (rad_ctl),
      .root    (rad_root),
      .sq      (rad_sq),
      .out_nx  (rad_nx),
      .out_ny  (rad_ny)
   );

   // Distortion, focal scaling and principal point, six stages.
   pppu_distort u_distort (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (rad_ctl),
      .root     (rad_root),
      .sq       (rad_sq),
      .nx       (rad_nx),
      .ny       (rad_ny),
      .focal_x  (focal_x_ff),
      .focal_y  (focal_y_ff),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .dist_k1  (dist_k1_ff),
      .dist_k2  (dist_k2_ff),
      .out_ctl  (out_ctl),
      .image_u  (rsp_image_u),
      .image_v  (rsp_image_v)
   );

   assign rsp_valid = out_ctl.valid;
   assign rsp_zero_depth = out_ctl.zero;

   // Both division lanes see the same depth, so their status must agree. The
   // depth flag only carries meaning while the lane holds a valid request.
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      div_ctl_x.valid == div_ctl_y.valid
      && (!div_ctl_x.valid || div_ctl_x.zero == div_ctl_y.zero))
      else $error("division lanes out of step");

   // A zero depth result carries zero coordinates.
   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_depth |-> rsp_image_u == '0 && rsp_image_v == '0)
      else $error("zero depth result with nonzero coordinates");

   // Every request comes out after the fixed pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("request lost in the pipeline");

   // No result appears without a request the pipeline depth before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a request");

endmodule
